### rtl/aes_xts_encrypt_engine_unit_defines.svh
// Assertion macros for the XTS encryption engine.
// Used by the modules in rtl that check their own control logic.
`ifndef AES_XTS_ENCRYPT_ENGINE_UNIT_DEFINES_SVH
`define AES_XTS_ENCRYPT_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define AXE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AXE_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AXE_ASSERT(lbl, clk, rst_n, prop, msg)
`define AXE_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/axe_pkg.sv
// Shared types, constants and AES helper functions for the XTS engine.
// No dependencies.
`timescale 1ns / 1ps
package axe_pkg;

    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_W0   = 3'd1;
    localparam logic [2:0] REG_KEY_W1   = 3'd2;
    localparam logic [2:0] REG_KEY_W2   = 3'd3;
    localparam logic [2:0] REG_KEY_W3   = 3'd4;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;
    localparam logic [1:0] KS_ALT = 2'd3;

    localparam logic [4:0] FULL_BYTES = 5'd16;
    localparam logic [7:0] GF_POLY    = 8'h87;
    localparam logic [7:0] AES_POLY   = 8'h1b;

    typedef enum logic [1:0] {KIND_IV, KIND_FULL, KIND_SHORT} kind_t;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} bstate_t;

    typedef struct packed {
        kind_t        kind;
        logic         fin;
        logic [4:0]   nbytes;
        logic [127:0] data;
    } item_t;

    typedef struct packed {
        logic [127:0] data;
        logic [4:0]   nbytes;
        logic         last;
    } result_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? AES_POLY : 8'h00);
    endfunction

    // SubBytes, ShiftRows and, unless last, MixColumns
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0]   sb [16];
        logic [7:0]   t [16];
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3, x;
        for (int i = 0; i < 16; i++) begin
            sb[i] = SBOX[s[8*i +: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[4*c+i] = sb[4*((c+i) % 4) + i];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c];
            a1 = t[4*c+1];
            a2 = t[4*c+2];
            a3 = t[4*c+3];
            x  = a0 ^ a1 ^ a2 ^ a3;
            if (last) begin
                o[32*c +: 32] = {a3, a2, a1, a0};
            end else begin
                o[32*c      +: 8] = a0 ^ x ^ xtime(a0 ^ a1);
                o[32*c + 8  +: 8] = a1 ^ x ^ xtime(a1 ^ a2);
                o[32*c + 16 +: 8] = a2 ^ x ^ xtime(a2 ^ a3);
                o[32*c + 24 +: 8] = a3 ^ x ^ xtime(a3 ^ a0);
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] gf_alpha(input logic [127:0] t);
        logic [127:0] o;
        o = {t[126:0], 1'b0};
        o[7:0] = o[7:0] ^ (t[127] ? GF_POLY : 8'h00);
        return o;
    endfunction

    function automatic logic [127:0] byte_mask(input logic [4:0] n);
        logic [127:0] m;
        for (int b = 0; b < 16; b++) begin
            m[8*b +: 8] = (5'(b) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

### rtl/axe_if.sv
// Item channel interfaces for the XTS engine: plaintext in, ciphertext out.
// No dependencies.
`timescale 1ns / 1ps
interface axe_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] word_lo;
    logic [63:0] word_hi;
    logic [4:0]  byte_count;
    logic        final_req;
    modport source (output valid, action, word_lo, word_hi, byte_count, final_req,
                    input ready);
    modport sink (input valid, action, word_lo, word_hi, byte_count, final_req,
                  output ready);
endinterface

interface axe_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_lo;
    logic [63:0] out_hi;
    logic [4:0]  out_bytes;
    logic        last_of_unit;
    modport source (output valid, out_lo, out_hi, out_bytes, last_of_unit, input ready);
    modport sink (input valid, out_lo, out_hi, out_bytes, last_of_unit, output ready);
endinterface

### rtl/aes_xts_encrypt_engine_unit.sv
// XTS-AES encryption engine with ciphertext stealing.
// Channels: in_ch sink takes IV items (action 0) and plaintext blocks (action 1);
// out_ch source gives ciphertext results, up to two per item, in order.
// APB port: key_size at 0x00, key words 0..3 at 0x08..0x20, 64-bit data, no wait states.
// After reset and after each key register write the key schedule computes 44, 52
// or 60 round key words (128/192/256-bit key); in_ch.ready stays low meanwhile.
// Items are queued two deep in front of a round-serial AES unit, which computes one
// round per cycle through a single round unit; this sets the sustained rate. The unit
// pops the next item only after it has finished the current one and stored its results.
// Non-final blocks yield no result until the next block arrives (one block is held
// for stealing). A stalled receiver fills a four-entry result queue; the AES unit
// then waits at the end of its item and the input queue backs up.
// Reset clears tweak, held state, queues and key registers.
// Depends on axe_pkg, axe_if, axe_keyexp, axe_front, axe_back.
`timescale 1ns / 1ps
module aes_xts_encrypt_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    axe_in_if.sink      in_ch,
    axe_out_if.source   out_ch
);
    logic [1:0]     key_size_reg;
    logic [63:0]    key_word_reg [4];
    logic [2:0]     ridx;
    logic           wr, kstart, kbusy;
    logic [3:0]     nr, rk_addr;
    logic [127:0]   rk_data;
    logic           q_valid, q_pop;
    axe_pkg::item_t q_item;

    assign pready = 1'b1;
    assign ridx   = paddr[5:3];
    assign wr     = psel && penable && pwrite;
    assign kstart = wr && (ridx <= axe_pkg::REG_KEY_W3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= axe_pkg::KS_128;
            for (int k = 0; k < 4; k++)
            begin
                key_word_reg[k] <= '0;
            end
        end
        else if (wr)
        begin
            case (ridx)
                axe_pkg::REG_KEY_SIZE:
                    key_size_reg <= (pwdata[1:0] == axe_pkg::KS_ALT) ? axe_pkg::KS_256 : pwdata[1:0];
                axe_pkg::REG_KEY_W0: key_word_reg[0] <= pwdata;
                axe_pkg::REG_KEY_W1: key_word_reg[1] <= pwdata;
                axe_pkg::REG_KEY_W2: key_word_reg[2] <= pwdata;
                axe_pkg::REG_KEY_W3: key_word_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            axe_pkg::REG_KEY_SIZE: prdata = {62'd0, key_size_reg};
            axe_pkg::REG_KEY_W0:   prdata = key_word_reg[0];
            axe_pkg::REG_KEY_W1:   prdata = key_word_reg[1];
            axe_pkg::REG_KEY_W2:   prdata = key_word_reg[2];
            axe_pkg::REG_KEY_W3:   prdata = key_word_reg[3];
            default:               prdata = '0;
        endcase
    end

    axe_keyexp u_keyexp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (kstart),
        .key_size (key_size_reg),
        .key      ({key_word_reg[3], key_word_reg[2], key_word_reg[1], key_word_reg[0]}),
        .rk_addr  (rk_addr),
        .rk_data  (rk_data),
        .nr       (nr),
        .busy     (kbusy)
    );

    axe_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .hold    (kbusy),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    axe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .nr      (nr),
        .rk_addr (rk_addr),
        .rk_data (rk_data),
        .out_ch  (out_ch)
    );
endmodule

### rtl/axe_keyexp.sv
// AES key schedule, one 32-bit word a cycle, into a 15-entry round key store.
// Depends on axe_pkg.
`timescale 1ns / 1ps
module axe_keyexp (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [1:0]   key_size,
    input  logic [255:0] key,
    input  logic [3:0]   rk_addr,
    output logic [127:0] rk_data,
    output logic [3:0]   nr,
    output logic         busy
);
    logic [127:0] rk_mem [15];
    logic [31:0]  win_reg [8];
    logic [5:0]   idx_reg, idx_next;
    logic [2:0]   mod_reg, mod_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic         busy_reg;
    logic [3:0]   nk;
    logic [5:0]   total;
    logic [31:0]  prev, back, tw, word_new;

    always_comb
    begin
        case (key_size)
            axe_pkg::KS_128:
            begin
                nk = 4'd4; nr = 4'd10; total = 6'd44; back = win_reg[4];
            end
            axe_pkg::KS_192:
            begin
                nk = 4'd6; nr = 4'd12; total = 6'd52; back = win_reg[2];
            end
            default:
            begin
                nk = 4'd8; nr = 4'd14; total = 6'd60; back = win_reg[0];
            end
        endcase
    end

    always_comb
    begin
        prev = win_reg[7];
        tw   = prev;
        rcon_next = rcon_reg;
        if (mod_reg == 3'd0)
        begin
            tw = {axe_pkg::SBOX[prev[7:0]], axe_pkg::SBOX[prev[31:24]],
                  axe_pkg::SBOX[prev[23:16]], axe_pkg::SBOX[prev[15:8]] ^ rcon_reg};
        end
        else if (nk == 4'd8 && mod_reg == 3'd4)
        begin
            tw = {axe_pkg::SBOX[prev[31:24]], axe_pkg::SBOX[prev[23:16]],
                  axe_pkg::SBOX[prev[15:8]], axe_pkg::SBOX[prev[7:0]]};
        end
        if ({2'b00, idx_reg} < {4'd0, nk})
        begin
            word_new = key[32*idx_reg[2:0] +: 32];
        end
        else
        begin
            word_new = back ^ tw;
            if (mod_reg == 3'd0)
            begin
                rcon_next = axe_pkg::xtime(rcon_reg);
            end
        end
        idx_next = idx_reg + 6'd1;
        mod_next = ({1'b0, mod_reg} == nk - 4'd1) ? 3'd0 : mod_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else if (busy_reg)
        begin
            idx_reg  <= idx_next;
            mod_reg  <= mod_next;
            rcon_reg <= rcon_next;
            busy_reg <= (idx_next != total);
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            rk_mem[idx_reg[5:2]][32*idx_reg[1:0] +: 32] <= word_new;
            for (int k = 0; k < 7; k++)
            begin
                win_reg[k] <= win_reg[k+1];
            end
            win_reg[7] <= word_new;
        end
    end

    assign rk_data = rk_mem[rk_addr];
    assign busy    = busy_reg;
endmodule

### rtl/axe_front.sv
// Front end: accept items, classify them and hold them in a two-entry queue.
// Depends on axe_pkg and axe_in_if.
`timescale 1ns / 1ps
module axe_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           hold,
    axe_in_if.sink         in_ch,
    output logic           q_valid,
    output axe_pkg::item_t q_item,
    input  logic           q_pop
);
    axe_pkg::item_t q_mem [2];
    logic           wptr_reg, rptr_reg;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    axe_pkg::item_t cls;

    always_comb
    begin
        cls.data = {in_ch.word_hi, in_ch.word_lo};
        cls.fin  = in_ch.final_req;
        if (!in_ch.action)
        begin
            cls.kind   = axe_pkg::KIND_IV;
            cls.nbytes = axe_pkg::FULL_BYTES;
        end
        else if (in_ch.final_req && (in_ch.byte_count inside {[5'd1:5'd15]}))
        begin
            cls.kind   = axe_pkg::KIND_SHORT;
            cls.nbytes = in_ch.byte_count;
        end
        else
        begin
            cls.kind   = axe_pkg::KIND_FULL;
            cls.nbytes = axe_pkg::FULL_BYTES;
        end
    end

    assign in_ch.ready = !hold && (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign q_item      = q_mem[rptr_reg];
    assign cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_reg ^ push;
            rptr_reg <= rptr_reg ^ q_pop;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wptr_reg] <= cls;
        end
    end
endmodule

### rtl/axe_back.sv
// Back end: round-serial AES, tweak update, held block for stealing, result queue.
// Depends on axe_pkg, axe_out_if and the assertion macro header.
`timescale 1ns / 1ps
`include "aes_xts_encrypt_engine_unit_defines.svh"
module axe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  axe_pkg::item_t q_item,
    output logic           q_pop,
    input  logic [3:0]     nr,
    output logic [3:0]     rk_addr,
    input  logic [127:0]   rk_data,
    axe_out_if.source      out_ch
);
    axe_pkg::bstate_t state_reg, state_next;
    axe_pkg::item_t   cur_reg;
    axe_pkg::result_t o_mem [4];
    axe_pkg::result_t p0, p1;
    logic [127:0] st_reg, tweak_reg, tw_use_reg, held_reg;
    logic         held_valid_reg;
    logic [3:0]   rnd_reg;
    logic [1:0]   wptr_reg, rptr_reg;
    logic [2:0]   ocnt_reg;
    logic [1:0]   npush;
    logic         finish, opop;
    logic [127:0] tw_eff, msk_in, msk_cur, pt, cres;

    always_comb
    begin
        state_next = state_reg;
        q_pop  = 1'b0;
        finish = 1'b0;
        case (state_reg)
            axe_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    state_next = axe_pkg::ST_RUN;
                end
            end
            axe_pkg::ST_RUN:
            begin
                if (rnd_reg == nr)
                begin
                    state_next = axe_pkg::ST_DONE;
                end
            end
            axe_pkg::ST_DONE:
            begin
                if (ocnt_reg <= 3'd2)
                begin
                    finish = 1'b1;
                    state_next = axe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = axe_pkg::ST_IDLE;
            end
        endcase
    end

    assign rk_addr = (state_reg == axe_pkg::ST_IDLE) ? 4'd0 : rnd_reg;

    // load path
    always_comb
    begin
        msk_in = axe_pkg::byte_mask(q_item.nbytes);
        tw_eff = tweak_reg;
        if (q_item.kind == axe_pkg::KIND_SHORT && !held_valid_reg)
        begin
            tw_eff = axe_pkg::gf_alpha(tweak_reg);
        end
        case (q_item.kind)
            axe_pkg::KIND_IV:    pt = q_item.data;
            axe_pkg::KIND_SHORT: pt = held_valid_reg ?
                                      ((q_item.data & msk_in) | (held_reg & ~msk_in)) ^ tw_eff :
                                      (q_item.data & msk_in) ^ tw_eff;
            default:             pt = q_item.data ^ tw_eff;
        endcase
    end

    // finish path
    always_comb
    begin
        msk_cur = axe_pkg::byte_mask(cur_reg.nbytes);
        cres    = st_reg ^ tw_use_reg;
        p0      = '{data: held_reg, nbytes: axe_pkg::FULL_BYTES, last: 1'b0};
        p1      = '{data: cres, nbytes: axe_pkg::FULL_BYTES, last: 1'b1};
        npush   = 2'd0;
        case (cur_reg.kind)
            axe_pkg::KIND_FULL:
            begin
                if (held_valid_reg && cur_reg.fin)
                begin
                    npush = 2'd2;
                end
                else if (held_valid_reg)
                begin
                    npush = 2'd1;
                end
                else if (cur_reg.fin)
                begin
                    p0 = p1;
                    npush = 2'd1;
                end
            end
            axe_pkg::KIND_SHORT:
            begin
                if (held_valid_reg)
                begin
                    p0 = '{data: cres, nbytes: axe_pkg::FULL_BYTES, last: 1'b0};
                    p1 = '{data: held_reg & msk_cur, nbytes: cur_reg.nbytes, last: 1'b1};
                    npush = 2'd2;
                end
                else
                begin
                    p0 = '{data: cres & msk_cur, nbytes: cur_reg.nbytes, last: 1'b1};
                    npush = 2'd1;
                end
            end
            default:
            begin
                npush = 2'd0;
            end
        endcase
        if (!finish)
        begin
            npush = 2'd0;
        end
    end

    assign opop = out_ch.valid && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= axe_pkg::ST_IDLE;
            rnd_reg        <= 4'd1;
            tweak_reg      <= '0;
            held_valid_reg <= 1'b0;
            wptr_reg       <= '0;
            rptr_reg       <= '0;
            ocnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == axe_pkg::ST_RUN)
            begin
                rnd_reg <= rnd_reg + 4'd1;
            end
            else
            begin
                rnd_reg <= 4'd1;
            end
            if (q_pop && q_item.kind == axe_pkg::KIND_SHORT && !held_valid_reg)
            begin
                tweak_reg <= tw_eff;
            end
            if (finish)
            begin
                if (cur_reg.kind == axe_pkg::KIND_IV)
                begin
                    tweak_reg      <= st_reg;
                    held_valid_reg <= 1'b0;
                end
                else
                begin
                    tweak_reg      <= axe_pkg::gf_alpha(tw_use_reg);
                    held_valid_reg <= (cur_reg.kind == axe_pkg::KIND_FULL) && !cur_reg.fin;
                end
            end
            wptr_reg <= wptr_reg + npush;
            rptr_reg <= rptr_reg + {1'b0, opop};
            ocnt_reg <= ocnt_reg + {1'b0, npush} - {2'b00, opop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg    <= q_item;
            tw_use_reg <= tw_eff;
            st_reg     <= pt ^ rk_data;
        end
        else if (state_reg == axe_pkg::ST_RUN)
        begin
            st_reg <= axe_pkg::aes_round(st_reg, rnd_reg == nr) ^ rk_data;
        end
        if (finish && cur_reg.kind == axe_pkg::KIND_FULL && !cur_reg.fin)
        begin
            held_reg <= cres;
        end
        if (npush != 2'd0)
        begin
            o_mem[wptr_reg] <= p0;
        end
        if (npush == 2'd2)
        begin
            o_mem[wptr_reg + 2'd1] <= p1;
        end
    end

    assign out_ch.valid        = (ocnt_reg != 3'd0);
    assign out_ch.out_hi       = o_mem[rptr_reg].data[127:64];
    assign out_ch.out_lo       = o_mem[rptr_reg].data[63:0];
    assign out_ch.out_bytes    = o_mem[rptr_reg].nbytes;
    assign out_ch.last_of_unit = o_mem[rptr_reg].last;

    `AXE_NEVER(a_ocnt_range, clk, rst_n, ocnt_reg > 3'd4, "result queue overflow")
    `AXE_NEVER(a_push_idle, clk, rst_n, (npush != 2'd0) && !finish, "results pushed outside finish")
    `AXE_ASSERT(a_iv_clears, clk, rst_n, (finish && cur_reg.kind == axe_pkg::KIND_IV) |=> !held_valid_reg, "held block survives tweak load")
endmodule
